### design/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types and constants for the fingerprint packet deframer.
// ----------------------------------------------------------------------------
package fpd_pkg;

  // default sizing
  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int DATA_LIMIT_DEF      = 1024;

  // frame bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hEF;
  localparam logic [7:0] SYNC_SECOND = 8'h01;
  localparam logic [7:0] ID_ACK      = 8'h07;
  localparam logic [7:0] ID_DATA     = 8'h02;
  localparam logic [7:0] ID_LAST     = 8'h08;

  // byte positions within a frame
  localparam int POS_HUNT    = 0;
  localparam int POS_SYNC2   = 1;
  localparam int POS_ADDR    = 2;
  localparam int POS_ID      = 6;
  localparam int POS_LEN_HI  = 7;
  localparam int POS_LEN_LO  = 8;
  localparam int POS_BODY    = 9;
  localparam int HEADER_BYTES = 9;
  // acknowledge length is 8 bits, so an acknowledge frame ends below this
  localparam int ACK_FRAME_CAP = HEADER_BYTES + 255;

  // frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LENGTH   = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_ACK_ID   = 3'd3;
  localparam logic [2:0] ST_CONFIRM  = 3'd4;
  localparam logic [2:0] ST_DATA_ID  = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  // output word kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // register indexes
  localparam logic REG_ACK_LEN  = 1'b0;
  localparam logic REG_PACKAGED = 1'b1;

  typedef struct packed {
    logic [7:0] expected_ack_length;
    logic       packaged_mode;
  } cfg_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [7:0]  package_id;
    logic [7:0]  confirmation;
    logic        command_done;
    logic [10:0] data_total;
  } res_t;

endpackage

### design/fpd_cfg.sv
// ----------------------------------------------------------------------------
// fpd_cfg
// APB register file: acknowledge length and packaged mode.
// ----------------------------------------------------------------------------
module fpd_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output fpd_pkg::cfg_t cfg
);

  logic       wr_en;
  logic [7:0] ack_len;
  logic       packaged;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_len  <= 8'd3;
      packaged <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == fpd_pkg::REG_ACK_LEN) begin
        ack_len <= pwdata[7:0];
      end else begin
        packaged <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fpd_pkg::REG_ACK_LEN) begin
      prdata = {24'd0, ack_len};
    end else begin
      prdata = {31'd0, packaged};
    end
  end

  assign cfg.expected_ack_length = ack_len;
  assign cfg.packaged_mode       = packaged;

endmodule

### design/fpd_parser.sv
// ----------------------------------------------------------------------------
// fpd_parser
// Frame state and per-byte step logic; one byte processed per step.
// ----------------------------------------------------------------------------
module fpd_parser #(
  parameter int MAX_FRAME_BYTES = fpd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int DATA_LIMIT      = fpd_pkg::DATA_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          func,
  input  logic [7:0]    rx_byte,
  input  fpd_pkg::cfg_t cfg,
  output logic          res_valid,
  output fpd_pkg::res_t res
);

  localparam int FRAME_CAP = (MAX_FRAME_BYTES > fpd_pkg::ACK_FRAME_CAP) ?
                             MAX_FRAME_BYTES : fpd_pkg::ACK_FRAME_CAP;
  localparam int POS_W = $clog2(FRAME_CAP + 1);
  localparam int CNT_W = $clog2(DATA_LIMIT + 1);
  localparam int SUM_W = ((CNT_W > 16) ? CNT_W : 16) + 1;

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       cur_id, cur_id_next;
  logic [15:0]      flen, flen_next;
  logic [15:0]      rsum, rsum_next;
  logic [7:0]       chk_hi, chk_hi_next;
  logic [7:0]       first, first_next;
  logic             data_phase, data_phase_next;
  logic [CNT_W-1:0] dcount, dcount_next;

  logic [15:0]      len_full;
  logic [16:0]      pos_x, body_end;
  logic [SUM_W-1:0] dsum;
  logic             rep;
  logic [2:0]       rep_status;
  logic             rep_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      cur_id     <= '0;
      flen       <= '0;
      rsum       <= '0;
      chk_hi     <= '0;
      first      <= '0;
      data_phase <= 1'b0;
      dcount     <= '0;
    end else begin
      pos        <= pos_next;
      cur_id     <= cur_id_next;
      flen       <= flen_next;
      rsum       <= rsum_next;
      chk_hi     <= chk_hi_next;
      first      <= first_next;
      data_phase <= data_phase_next;
      dcount     <= dcount_next;
    end
  end

  assign len_full = {flen[15:8], rx_byte};
  assign pos_x    = 17'(pos);
  assign body_end = {1'b0, flen} + 17'd7;
  assign dsum     = SUM_W'(dcount) + SUM_W'(flen) - SUM_W'(2);

  always_comb begin
    pos_next        = pos;
    cur_id_next     = cur_id;
    flen_next       = flen;
    rsum_next       = rsum;
    chk_hi_next     = chk_hi;
    first_next      = first;
    data_phase_next = data_phase;
    dcount_next     = dcount;
    rep             = 1'b0;
    rep_status      = fpd_pkg::ST_OK;
    rep_done        = 1'b0;
    res_valid       = 1'b0;
    res             = '0;

    if (func) begin
      pos_next        = '0;
      cur_id_next     = '0;
      flen_next       = '0;
      rsum_next       = '0;
      chk_hi_next     = '0;
      first_next      = '0;
      data_phase_next = 1'b0;
      dcount_next     = '0;
    end else if (step) begin
      if (pos == POS_W'(fpd_pkg::POS_HUNT)) begin
        if (rx_byte == fpd_pkg::SYNC_FIRST) begin
          pos_next = POS_W'(fpd_pkg::POS_SYNC2);
        end
      end else if (pos == POS_W'(fpd_pkg::POS_SYNC2)) begin
        pos_next = (rx_byte == fpd_pkg::SYNC_SECOND) ? POS_W'(fpd_pkg::POS_ADDR) :
                                                       POS_W'(fpd_pkg::POS_HUNT);
      end else if (pos < POS_W'(fpd_pkg::POS_ID)) begin
        pos_next = pos + 1'b1;
      end else if (pos == POS_W'(fpd_pkg::POS_ID)) begin
        cur_id_next = rx_byte;
        rsum_next   = {8'd0, rx_byte};
        first_next  = '0;
        chk_hi_next = '0;
        pos_next    = POS_W'(fpd_pkg::POS_LEN_HI);
      end else if (pos == POS_W'(fpd_pkg::POS_LEN_HI)) begin
        flen_next = {rx_byte, 8'd0};
        rsum_next = rsum + {8'd0, rx_byte};
        pos_next  = POS_W'(fpd_pkg::POS_LEN_LO);
      end else if (pos == POS_W'(fpd_pkg::POS_LEN_LO)) begin
        flen_next = len_full;
        rsum_next = rsum + {8'd0, rx_byte};
        pos_next  = POS_W'(fpd_pkg::POS_BODY);
        if (!data_phase) begin
          if (len_full != {8'd0, cfg.expected_ack_length} || len_full < 16'd2) begin
            rep        = 1'b1;
            rep_status = fpd_pkg::ST_LENGTH;
            rep_done   = 1'b1;
          end
        end else if (len_full < 16'd2 ||
                     ({1'b0, len_full} + 17'(fpd_pkg::HEADER_BYTES)) >
                     17'(MAX_FRAME_BYTES)) begin
          rep        = 1'b1;
          rep_status = fpd_pkg::ST_OVERFLOW;
          rep_done   = 1'b1;
        end
      end else if (pos_x < body_end) begin
        // payload byte: pass through
        if (pos == POS_W'(fpd_pkg::POS_BODY)) begin
          first_next = rx_byte;
        end
        rsum_next        = rsum + {8'd0, rx_byte};
        pos_next         = pos + 1'b1;
        res_valid        = 1'b1;
        res.out_kind     = fpd_pkg::KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.package_id   = cur_id;
      end else if (pos_x == body_end) begin
        chk_hi_next = rx_byte;
        pos_next    = pos + 1'b1;
      end else begin
        // checksum low byte: frame end
        rep = 1'b1;
        if ({chk_hi, rx_byte} != rsum) begin
          rep_status = fpd_pkg::ST_CHECKSUM;
          rep_done   = 1'b1;
        end else if (!data_phase) begin
          if (cur_id != fpd_pkg::ID_ACK) begin
            rep_status = fpd_pkg::ST_ACK_ID;
            rep_done   = 1'b1;
          end else if (first != 8'd0) begin
            rep_status = fpd_pkg::ST_CONFIRM;
            rep_done   = 1'b1;
          end else if (cfg.packaged_mode) begin
            data_phase_next = 1'b1;
            dcount_next     = '0;
          end else begin
            rep_done = 1'b1;
          end
        end else if (cur_id != fpd_pkg::ID_DATA && cur_id != fpd_pkg::ID_LAST) begin
          rep_status = fpd_pkg::ST_DATA_ID;
          rep_done   = 1'b1;
        end else if (dsum > SUM_W'(DATA_LIMIT)) begin
          rep_status = fpd_pkg::ST_OVERFLOW;
          rep_done   = 1'b1;
        end else begin
          dcount_next = CNT_W'(dsum);
          rep_done    = (cur_id == fpd_pkg::ID_LAST);
        end
      end

      if (rep) begin
        pos_next         = '0;
        if (rep_done) begin
          data_phase_next = 1'b0;
        end
        res_valid        = 1'b1;
        res.out_kind     = fpd_pkg::KIND_REPORT;
        res.frame_status = rep_status;
        res.package_id   = cur_id;
        res.confirmation = first;
        res.command_done = rep_done;
        res.data_total   = 11'(SUM_W'(dcount_next));
      end
    end
  end

endmodule

### design/fingerprint_packet_deframer.sv
// ----------------------------------------------------------------------------
// fingerprint_packet_deframer
// Byte-stream deframer for fingerprint sensor reply frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one word per byte from the serial
//   link. func=0 feeds rx_byte into the deframer, func=1 starts a new command
//   and clears all frame state without producing an output word.
//   Output channel (out_valid/out_stall): one word per payload byte
//   (out_kind=0) and one report per finished or rejected frame (out_kind=1).
//   Sync bytes, address, ID, length and checksum bytes produce no payload word.
//   APB port: register 0 at 0x0 is the expected acknowledge length, register
//   1 at 0x4 is packaged mode. Write only while the block is idle.
// Timing:
//   A word accepted sits in the input register, is processed from there into
//   the output register, and can then be taken from the output channel.
//   One byte per cycle is sustained while out_stall is low; the single per-byte
//   step (counter, sum and compare) between the two registers sets that rate.
// Reset (rst, synchronous): both registers empty, deframer hunting for sync
//   in acknowledge phase, ack length 3, packaged mode off.
// Stall: a stalled output word holds; the input register keeps taking one
//   more byte, then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module fingerprint_packet_deframer #(
  parameter int MAX_FRAME_BYTES = fpd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int DATA_LIMIT      = fpd_pkg::DATA_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  frame_status,
  output logic [7:0]  package_id,
  output logic [7:0]  confirmation,
  output logic        command_done,
  output logic [10:0] data_total,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fpd_pkg::cfg_t cfg;
  fpd_pkg::res_t res;
  fpd_pkg::res_t res_q;
  logic          res_valid;

  // input register
  logic       in_full;
  logic       func_q;
  logic [7:0] byte_q;
  logic       in_accept;
  logic       advance;

  fpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the held byte moves on when the output register is free or draining
  assign advance   = in_full & (~out_valid | ~out_stall);
  assign in_stall  = in_full & ~advance;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_q <= func;
      byte_q <= rx_byte;
    end
  end

  fpd_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .DATA_LIMIT      (DATA_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .func      (advance & func_q),
    .rx_byte   (byte_q),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance & res_valid) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance & res_valid) begin
      res_q <= res;
    end
  end

  assign out_kind     = res_q.out_kind;
  assign payload_byte = res_q.payload_byte;
  assign frame_status = res_q.frame_status;
  assign package_id   = res_q.package_id;
  assign confirmation = res_q.confirmation;
  assign command_done = res_q.command_done;
  assign data_total   = res_q.data_total;

endmodule

### tb/sv/fingerprint_packet_deframer_test.sv
// ----------------------------------------------------------------------------
// fingerprint_packet_deframer_test
// Self-checking bench for the sensor reply deframer. A short table of
// hand-checked bytes comes first. Then whole reply sequences with random
// content are sent: acknowledge frames, data frames and broken frames, under
// several register settings. Every output word is checked against the word
// of its hand-written table row or a cycle-free model of the frame parser.
// ----------------------------------------------------------------------------
module fingerprint_packet_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpd_pkg::*;

  localparam int HOLD_CYCLES = 150;  // long receiver hold-off, fills the pipe
  localparam int SETTLE      = 4;    // input reg + output reg, plus margin
  localparam int PHASE_ITEMS = 75;   // counted bytes per register setting, at least
  localparam int NUM_PHASES  = 4;

  // first payload byte of a generated frame
  localparam int FIRST_ZERO = 0;
  localparam int FIRST_SET  = 1;
  localparam int FIRST_ANY  = 2;

  typedef struct {
    logic       f;
    logic [7:0] b;
    bit         pinned;  // row carries a hand-written expected word
    res_t       want;
  } step_row_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_status;
  logic [7:0]  package_id;
  logic [7:0]  confirmation;
  logic        command_done;
  logic [10:0] data_total;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  fingerprint_packet_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .payload_byte (payload_byte),
    .frame_status (frame_status),
    .package_id   (package_id),
    .confirmation (confirmation),
    .command_done (command_done),
    .data_total   (data_total),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Frame parser model: register mirror and parser state
  // --------------------------------------------------------------------------
  logic [7:0]  ack_len_cfg  = 8'd3;
  logic        packaged_cfg = 1'b0;

  int          frame_pos  = 0;     // byte index in frame, 0 = hunting sync
  logic [7:0]  cur_id     = 8'h00;
  logic [15:0] frame_len  = 16'h0000;
  logic [15:0] run_sum    = 16'h0000;
  logic [7:0]  sum_hi     = 8'h00;
  logic [7:0]  conf_byte  = 8'h00;
  logic        data_phase = 1'b0;
  int          data_cnt   = 0;

  res_t        pending_words[$];   // words the block still owes us

  // bench bookkeeping
  int          errors = 0;
  int          sent_bytes = 0;
  int          noise_bytes = 0;
  int          payload_words = 0;
  int          status_seen[0:6] = '{default: 0};
  bit          calm = 1'b0;        // no idling on either side
  bit          dirty = 1'b0;       // parser may be mid-frame after noise
  bit          hold_off_req = 1'b0;
  int          src_gap_pct = 10;
  int          sink_stall_pct = 10;
  res_t        got_w;
  res_t        want_w;

  // End-of-frame word; also drops back to hunting, and ends the data phase
  // when the sequence is done.
  function automatic res_t frame_report(input logic [2:0] st, input logic done);
    res_t r;
    r = '0;
    r.out_kind     = KIND_REPORT;
    r.frame_status = st;
    r.package_id   = cur_id;
    r.confirmation = conf_byte;
    r.command_done = done;
    r.data_total   = 11'(data_cnt);
    frame_pos = POS_HUNT;
    if (done) data_phase = 1'b0;
    return r;
  endfunction

  // One input byte through the parser. hit says whether a word comes out.
  task automatic deframe_byte(input logic f, input logic [7:0] b,
                              output bit hit, output res_t r);
    int p;
    p   = frame_pos;
    hit = 1'b0;
    r   = '0;
    if (f) begin
      // new command: everything back to reset values, registers kept
      frame_pos  = POS_HUNT;
      cur_id     = 8'h00;
      frame_len  = 16'h0000;
      run_sum    = 16'h0000;
      sum_hi     = 8'h00;
      conf_byte  = 8'h00;
      data_phase = 1'b0;
      data_cnt   = 0;
    end else if (p == POS_HUNT) begin
      if (b == SYNC_FIRST) frame_pos = POS_SYNC2;
    end else if (p == POS_SYNC2) begin
      frame_pos = (b == SYNC_SECOND) ? POS_ADDR : POS_HUNT;
    end else if (p < POS_ID) begin
      frame_pos = p + 1;             // address bytes are skipped
    end else if (p == POS_ID) begin
      cur_id    = b;
      run_sum   = {8'h00, b};
      conf_byte = 8'h00;
      sum_hi    = 8'h00;
      frame_pos = POS_LEN_HI;
    end else if (p == POS_LEN_HI) begin
      frame_len = {b, 8'h00};
      run_sum   = run_sum + {8'h00, b};
      frame_pos = POS_LEN_LO;
    end else if (p == POS_LEN_LO) begin
      frame_len[7:0] = b;
      run_sum   = run_sum + {8'h00, b};
      frame_pos = POS_BODY;
      // header checks fire right here, before any body byte
      if (!data_phase) begin
        if (frame_len != {8'h00, ack_len_cfg} || frame_len < 16'd2) begin
          r = frame_report(ST_LENGTH, 1'b1);
          hit = 1'b1;
        end
      end else if (frame_len < 16'd2 ||
                   HEADER_BYTES + int'(frame_len) > MAX_FRAME_BYTES_DEF) begin
        r = frame_report(ST_OVERFLOW, 1'b1);
        hit = 1'b1;
      end
    end else if (p < 7 + int'(frame_len)) begin
      // payload passes straight through
      if (p == POS_BODY) conf_byte = b;
      run_sum   = run_sum + {8'h00, b};
      frame_pos = p + 1;
      r.out_kind     = KIND_PAYLOAD;
      r.payload_byte = b;
      r.package_id   = cur_id;
      hit = 1'b1;
    end else if (p == 7 + int'(frame_len)) begin
      sum_hi    = b;
      frame_pos = p + 1;
    end else begin
      // checksum low byte: frame checks in priority order
      hit = 1'b1;
      if ({sum_hi, b} != run_sum) begin
        r = frame_report(ST_CHECKSUM, 1'b1);
      end else if (!data_phase) begin
        if (cur_id != ID_ACK) begin
          r = frame_report(ST_ACK_ID, 1'b1);
        end else if (conf_byte != 8'h00) begin
          r = frame_report(ST_CONFIRM, 1'b1);
        end else if (packaged_cfg) begin
          data_phase = 1'b1;
          data_cnt   = 0;
          r = frame_report(ST_OK, 1'b0);
        end else begin
          r = frame_report(ST_OK, 1'b1);
        end
      end else if (cur_id != ID_DATA && cur_id != ID_LAST) begin
        r = frame_report(ST_DATA_ID, 1'b1);
      end else if (data_cnt + int'(frame_len) - 2 > DATA_LIMIT_DEF) begin
        r = frame_report(ST_OVERFLOW, 1'b1);
      end else begin
        data_cnt = data_cnt + int'(frame_len) - 2;
        r = frame_report(ST_OK, cur_id == ID_LAST);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: field-by-field compare against the oldest pending word
  // --------------------------------------------------------------------------
  task automatic check_word(input res_t want, input res_t got);
    if (got.out_kind !== want.out_kind) begin
      $error("out_kind: expected %0h, got %0h", want.out_kind, got.out_kind);
      errors++;
    end
    if (got.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
      errors++;
    end
    if (got.frame_status !== want.frame_status) begin
      $error("frame_status: expected %0h, got %0h", want.frame_status, got.frame_status);
      errors++;
    end
    if (got.package_id !== want.package_id) begin
      $error("package_id: expected %0h, got %0h", want.package_id, got.package_id);
      errors++;
    end
    if (got.confirmation !== want.confirmation) begin
      $error("confirmation: expected %0h, got %0h", want.confirmation, got.confirmation);
      errors++;
    end
    if (got.command_done !== want.command_done) begin
      $error("command_done: expected %0h, got %0h", want.command_done, got.command_done);
      errors++;
    end
    if (got.data_total !== want.data_total) begin
      $error("data_total: expected %0h, got %0h", want.data_total, got.data_total);
      errors++;
    end
  endtask

  // Sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_w = {out_kind, payload_byte, frame_status, package_id,
               confirmation, command_done, data_total};
      if (pending_words.size() == 0) begin
        $error("unexpected output word: kind %0h, byte %0h, status %0h",
               out_kind, payload_byte, frame_status);
        errors++;
      end else begin
        want_w = pending_words.pop_front();
        if (want_w.out_kind == KIND_REPORT) status_seen[want_w.frame_status]++;
        else payload_words++;
        check_word(want_w, got_w);
      end
    end
  end

  // Receiver: random stall bursts, clean stretches, and one long hold-off
  // on request so the block backs up into its input.
  initial begin : sink_side
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic int pick_rate();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 8;
      default: return 30;
    endcase
  endfunction

  // Offer one word and hold it until taken; the model sees it on acceptance.
  task automatic send_word(input logic f, input logic [7:0] b,
                           input bit pinned, input res_t want);
    bit   hit;
    res_t r;
    if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    deframe_byte(f, b, hit, r);
    sent_bytes++;
    if (pinned) pending_words.push_back(want);
    else if (hit) pending_words.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b, 1'b0, '0);
  endtask

  // Pause the sender until every owed word is out, then let the pipe empty.
  task automatic wait_all_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write, then read back through the same port.
  task automatic reg_write(input logic idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (idx == REG_ACK_LEN) ? 32'h0000_00FF : 32'h0000_0001;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== (val & mask)) begin
      $error("register %0d readback: expected %0h, got %0h", idx, val & mask, rd & mask);
      errors++;
    end
    if (idx == REG_ACK_LEN) ack_len_cfg = val[7:0];
    else packaged_cfg = val[0];
    @(posedge clk);
  endtask

  // A full frame with random address and payload. hdr_only stops after the
  // length field, for frames the block rejects at header time.
  task automatic send_frame(input logic [7:0] id, input logic [15:0] len,
                            input int first_mode, input bit bad_sum,
                            input bit hdr_only);
    logic [15:0] sum;
    logic [7:0]  pb;
    int          k;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    repeat (4) send_byte(8'($urandom));
    send_byte(id);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (!hdr_only) begin
      sum = {8'h00, id} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
      for (k = 0; k < int'(len) - 2; k++) begin
        pb = 8'($urandom);
        if (k == 0 && first_mode == FIRST_ZERO) pb = 8'h00;
        if (k == 0 && first_mode == FIRST_SET) pb = 8'($urandom_range(1, 255));
        sum = sum + {8'h00, pb};
        send_byte(pb);
      end
      if (bad_sum) sum = sum ^ 16'($urandom_range(1, 65535));
      send_byte(sum[15:8]);
      send_byte(sum[7:0]);
    end
  endtask

  function automatic logic [15:0] oversize_len();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'($urandom_range(MAX_FRAME_BYTES_DEF - HEADER_BYTES + 1, 300));
      default: return 16'($urandom_range(301, 65535));
    endcase
  endfunction

  // One command's reply: acknowledge, then data frames in packaged mode.
  // Most are well formed; a few carry one fault that ends the sequence.
  task automatic run_command();
    int          fault;
    int          dfault;
    int          nfr;
    int          k;
    bit          open_end;
    logic [15:0] len;
    logic [7:0]  id;
    src_gap_pct    = pick_rate();
    sink_stall_pct = pick_rate();
    if (dirty || $urandom_range(0, 2) == 0) send_word(1'b1, 8'($urandom), 1'b0, '0);
    dirty = 1'b0;

    fault = $urandom_range(0, 15);
    len   = {8'h00, ack_len_cfg};
    id    = ID_ACK;
    if (fault == 12) begin
      // wrong acknowledge length, reported at header end
      case ($urandom_range(0, 3))
        0:       len = 16'd0;
        1:       len = 16'd1;
        2:       len = {8'h00, ack_len_cfg + 8'd1};
        default: len = {8'($urandom_range(1, 255)), ack_len_cfg};
      endcase
      send_frame(id, len, FIRST_ZERO, 1'b0, 1'b1);
      return;
    end
    if (fault == 13)
      id = ($urandom_range(0, 1) != 0) ? ID_DATA : 8'($urandom_range(9, 255));
    send_frame(id, len, (fault == 14) ? FIRST_SET : FIRST_ZERO, fault == 15, 1'b0);
    if (fault >= 12 || !packaged_cfg) return;

    nfr      = $urandom_range(1, 4);
    open_end = ($urandom_range(0, 9) == 0);  // no closing frame, sequence stays open
    for (k = 0; k < nfr; k++) begin
      id  = (k == nfr - 1 && !open_end) ? ID_LAST : ID_DATA;
      len = ($urandom_range(0, 9) == 0) ?
            16'($urandom_range(2, MAX_FRAME_BYTES_DEF - HEADER_BYTES)) :
            16'($urandom_range(2, 16));
      dfault = $urandom_range(0, 19);
      if (dfault == 0) begin
        send_frame(ID_DATA, oversize_len(), FIRST_ANY, 1'b0, 1'b1);
        return;
      end
      if (dfault == 1)
        id = ($urandom_range(0, 1) != 0) ? ID_ACK : 8'($urandom_range(9, 255));
      send_frame(id, len, FIRST_ANY, dfault == 2, 1'b0);
      if (dfault == 1 || dfault == 2) return;
    end
  endtask

  // Packaged sequence that lands exactly on the data limit, then goes one
  // byte past it.
  task automatic run_bulk();
    int filled;
    send_word(1'b1, 8'h00, 1'b0, '0);
    send_frame(ID_ACK, {8'h00, ack_len_cfg}, FIRST_ZERO, 1'b0, 1'b0);
    filled = 0;
    while (DATA_LIMIT_DEF - filled > MAX_FRAME_BYTES_DEF - HEADER_BYTES - 2) begin
      send_frame(ID_DATA, 16'($urandom_range(200, MAX_FRAME_BYTES_DEF - HEADER_BYTES)),
                 FIRST_ANY, 1'b0, 1'b0);
      filled = DATA_LIMIT_DEF - (DATA_LIMIT_DEF - filled) +
               int'(frame_len) - 2;
    end
    send_frame(ID_DATA, 16'(DATA_LIMIT_DEF - filled + 2), FIRST_ANY, 1'b0, 1'b0);
    send_frame(ID_LAST, 16'd3, FIRST_ANY, 1'b0, 1'b0);
  endtask

  // Random bytes, sometimes behind a sync pair, sometimes with a clear.
  task automatic run_noise();
    int n;
    int k;
    n = $urandom_range(3, 24);
    if ($urandom_range(0, 1) != 0) begin
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      noise_bytes += 2;
    end
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 15) == 0) send_word(1'b1, 8'($urandom), 1'b0, '0);
      else send_byte(8'($urandom));
    end
    noise_bytes += n;
    dirty = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    step_row_t   plan[0:24];
    int          ph;
    int          mark;
    logic [7:0]  ack_len;
    logic        pk;

    // Directed bytes under reset settings (ack length 3, not packaged):
    // clear, a dropped hunt byte, a broken sync pair, a good acknowledge
    // with a zero confirmation, then a frame (ID 0xFF) with the wrong length.
    plan = '{
      '{1'b1, 8'hFF,       1'b0, '0},
      '{1'b0, 8'h00,       1'b0, '0},
      '{1'b0, SYNC_FIRST,  1'b0, '0},
      '{1'b0, 8'h55,       1'b0, '0},   // bad second sync byte
      '{1'b0, SYNC_FIRST,  1'b0, '0},
      '{1'b0, SYNC_SECOND, 1'b0, '0},
      '{1'b0, 8'hFF,       1'b0, '0},   // address
      '{1'b0, 8'h00,       1'b0, '0},
      '{1'b0, 8'hFF,       1'b0, '0},
      '{1'b0, 8'h00,       1'b0, '0},
      '{1'b0, ID_ACK,      1'b0, '0},
      '{1'b0, 8'h00,       1'b0, '0},   // length 3
      '{1'b0, 8'h03,       1'b0, '0},
      '{1'b0, 8'h00,       1'b1,        // confirmation byte passes through
        '{KIND_PAYLOAD, 8'h00, ST_OK, ID_ACK, 8'h00, 1'b0, 11'd0}},
      '{1'b0, 8'h00,       1'b0, '0},   // checksum 0x000A
      '{1'b0, 8'h0A,       1'b1,
        '{KIND_REPORT, 8'h00, ST_OK, ID_ACK, 8'h00, 1'b1, 11'd0}},
      '{1'b0, SYNC_FIRST,  1'b0, '0},
      '{1'b0, SYNC_SECOND, 1'b0, '0},
      '{1'b0, 8'h00,       1'b0, '0},
      '{1'b0, 8'h00,       1'b0, '0},
      '{1'b0, 8'h00,       1'b0, '0},
      '{1'b0, 8'h00,       1'b0, '0},
      '{1'b0, 8'hFF,       1'b0, '0},   // id
      '{1'b0, 8'h00,       1'b0, '0},   // length 255 vs 3: rejected at header
      '{1'b0, 8'hFF,       1'b1,
        '{KIND_REPORT, 8'h00, ST_LENGTH, 8'hFF, 8'h00, 1'b1, 11'd0}}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) send_word(plan[k].f, plan[k].b, plan[k].pinned, plan[k].want);
    wait_all_words();

    // Register settings: packaged with ack length 3, maximum ack length,
    // a random mid value, then back to the reset setting with no idling.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin ack_len = 8'd3;   pk = 1'b1; end
        1:       begin ack_len = 8'd255; pk = 1'b0; end
        2:       begin ack_len = 8'($urandom_range(4, 40)); pk = 1'b1; end
        default: begin ack_len = 8'd3;   pk = 1'b0; end
      endcase
      wait_all_words();
      reg_write(REG_ACK_LEN, {24'h0, ack_len});
      reg_write(REG_PACKAGED, {31'h0, pk});
      calm = (ph == NUM_PHASES - 1);

      if (ph == 0) begin
        // receiver goes quiet while the long sequence keeps coming
        hold_off_req = 1'b1;
        run_bulk();
      end

      mark = sent_bytes - noise_bytes;
      while (sent_bytes - noise_bytes < mark + PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) run_noise();
        else run_command();
        if ($urandom_range(0, 11) == 0) wait_all_words();
      end
    end

    wait_all_words();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes (%0d noise) over %0d register settings; %0d payload words.",
             sent_bytes, noise_bytes, NUM_PHASES + 1, payload_words);
    $display("Reports ok/len/sum/ackid/confirm/dataid/overflow: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("fingerprint_packet_deframer_test: done, clean");
    end else begin
      $display("fingerprint_packet_deframer_test: done, errors");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("Timeout: %0d words still pending", pending_words.size());
    $display("fingerprint_packet_deframer_test: done, errors");
    $finish;
  end

endmodule

### fingerprint_packet_deframer.f
design/fpd_pkg.sv
design/fpd_cfg.sv
design/fpd_parser.sv
design/fingerprint_packet_deframer.sv
tb/sv/fingerprint_packet_deframer_test.sv
